// ===== rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// Playfair stream encryptor package
// Types, letter codes, key-square reset value and square lookup functions.
// ----------------------------------------------------------------------------
package pse_pkg;

   localparam int SqSize    = 5;
   localparam int CodeWidth = 5;
   localparam int RowWidth  = SqSize * CodeWidth;
   localparam int PosWidth  = $clog2(SqSize);
   localparam int IdxWidth  = $clog2(SqSize);

   localparam logic [CodeWidth-1:0] CodeI = 5'd8;
   localparam logic [CodeWidth-1:0] CodeJ = 5'd9;
   localparam logic [CodeWidth-1:0] CodeX = 5'd23;

   localparam logic [7:0] AsciiUpperA = 8'h41;
   localparam logic [7:0] AsciiUpperZ = 8'h5A;
   localparam logic [7:0] AsciiLowerA = 8'h61;
   localparam logic [7:0] AsciiLowerZ = 8'h7A;

   typedef logic [CodeWidth-1:0]                code_type;
   typedef logic [PosWidth-1:0]                 pos_type;
   typedef logic [IdxWidth-1:0]                 csr_index_type;
   typedef logic [RowWidth-1:0]                 key_row_type;
   typedef key_row_type [SqSize-1:0]            key_square_type;

   // row 4 first: packed element order
   localparam key_square_type KeyReset = '{
      25'd2149955, 25'd6848868, 25'd25942713, 25'd17283508, 25'd10755244
   };

   typedef struct packed {
      pos_type row;
      pos_type col;
   } loc_type;

   // First match in row-major order; a missing letter sits at row 0, column 0.
   function automatic loc_type pse_locate(key_square_type sq, code_type code);
      loc_type loc;
      loc = '0;
      for (int r = SqSize - 1; r >= 0; r--) begin
         for (int c = SqSize - 1; c >= 0; c--) begin
            if (sq[r][c*CodeWidth +: CodeWidth] == code) begin
               loc.row = pos_type'(r);
               loc.col = pos_type'(c);
            end
         end
      end
      return loc;
   endfunction

   function automatic code_type pse_cell(key_square_type sq, pos_type row, pos_type col);
      return sq[row][col*CodeWidth +: CodeWidth];
   endfunction

   function automatic pos_type pse_wrap_inc(pos_type p);
      return (p == pos_type'(SqSize - 1)) ? '0 : pos_type'(p + 1'b1);
   endfunction

endpackage

// ===== rtl/pse_interfaces.sv =====
// ----------------------------------------------------------------------------
// Playfair stream encryptor channels
// Valid/ready interfaces for plaintext bytes, cipher letters and key writes.
// ----------------------------------------------------------------------------
interface pse_req_if;
   import pse_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, in_byte, end_of_text, input ready);
   modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

interface pse_rsp_if;
   import pse_pkg::*;
   logic       valid;
   logic       ready;
   logic [6:0] cipher_letter;
   logic       last_letter;

   modport source (output valid, cipher_letter, last_letter, input ready);
   modport sink   (input valid, cipher_letter, last_letter, output ready);
endinterface

interface pse_csr_if;
   import pse_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type reg_index;
   key_row_type   wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/playfair_stream_encryptor_core.sv =====
// ----------------------------------------------------------------------------
// Playfair stream encryptor core
// Path: a byte that completes a pair goes to the pair stage, then the result
//   buffer shows its first letter, the second on the next rsp transfer.
// Throughput: one byte per cycle unless the pair stage is held; each pair needs
//   two rsp transfers, so the letter port sets the rate.
// Reset: no letter pending, pipeline empty, key square back to its default.
// ----------------------------------------------------------------------------
module playfair_stream_encryptor_core (
   input logic   clock,
   input logic   reset,
   pse_req_if.sink   req_bus,
   pse_rsp_if.source rsp_bus,
   pse_csr_if.sink   csr_bus
);
   import pse_pkg::*;

   // key square
   key_square_type key_ff;

   // pairing state
   logic     pend_valid_ff, pend_valid_in;
   code_type pend_letter_ff, pend_letter_in;

   // pair stage
   logic     s1_valid_ff, s1_valid_in;
   code_type s1_a_ff, s1_b_ff;
   logic     s1_last_ff;

   // result buffer: two letters, count of letters still to transfer
   logic [1:0] out_cnt_ff;
   logic [6:0] out_e1_ff, out_e2_ff;
   logic       out_last_ff;

   logic       req_xfer, rsp_xfer, out_load_ok, s1_advance;
   logic       is_letter, letter_pairs, hold_after, emit;
   code_type   in_code, letter_after, pair_a, pair_b;
   loc_type    loc_a, loc_b;
   code_type   enc_1, enc_2;

   // ---------------------------------------------------------------------
   // Handshakes: take a new byte whenever the pair stage is free or moves on
   // ---------------------------------------------------------------------
   assign out_load_ok = (out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_bus.ready);
   assign s1_advance  = s1_valid_ff && out_load_ok;
   assign req_bus.ready = !s1_valid_ff || out_load_ok;
   assign req_xfer    = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = (out_cnt_ff != 2'd0);
   assign rsp_xfer    = rsp_bus.valid && rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   // ---------------------------------------------------------------------
   // Byte decode: drop non-letters, fold case, fold J onto I
   // ---------------------------------------------------------------------
   always_comb begin
      is_letter = 1'b0;
      in_code   = '0;
      if (req_bus.in_byte >= AsciiUpperA && req_bus.in_byte <= AsciiUpperZ) begin
         is_letter = 1'b1;
         in_code   = code_type'(req_bus.in_byte - AsciiUpperA);
      end else if (req_bus.in_byte >= AsciiLowerA && req_bus.in_byte <= AsciiLowerZ) begin
         is_letter = 1'b1;
         in_code   = code_type'(req_bus.in_byte - AsciiLowerA);
      end
      if (in_code == CodeJ) begin
         in_code = CodeI;
      end
   end

   // ---------------------------------------------------------------------
   // Pairing: a letter closes the held one, or becomes held; end of text
   // pads a lone held letter with X
   // ---------------------------------------------------------------------
   always_comb begin
      letter_pairs = is_letter && pend_valid_ff;
      hold_after   = is_letter ? !pend_valid_ff : pend_valid_ff;
      letter_after = (is_letter && !pend_valid_ff) ? in_code : pend_letter_ff;
      emit         = letter_pairs || (req_bus.end_of_text && hold_after);
      pair_a       = letter_pairs ? pend_letter_ff : letter_after;
      pair_b       = letter_pairs ? in_code : CodeX;

      pend_valid_in  = pend_valid_ff;
      pend_letter_in = pend_letter_ff;
      if (req_xfer) begin
         pend_valid_in  = hold_after && !req_bus.end_of_text && !letter_pairs;
         pend_letter_in = pend_valid_in ? letter_after : '0;
      end

      if (req_xfer) begin
         s1_valid_in = emit;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Encipher the held pair with the key square
   // ---------------------------------------------------------------------
   always_comb begin
      loc_a = pse_locate(key_ff, s1_a_ff);
      loc_b = pse_locate(key_ff, s1_b_ff);
      priority if (loc_a.row == loc_b.row) begin
         // same row, doubled letters included: shift right
         enc_1 = pse_cell(key_ff, loc_a.row, pse_wrap_inc(loc_a.col));
         enc_2 = pse_cell(key_ff, loc_b.row, pse_wrap_inc(loc_b.col));
      end else if (loc_a.col == loc_b.col) begin
         // same column: shift down
         enc_1 = pse_cell(key_ff, pse_wrap_inc(loc_a.row), loc_a.col);
         enc_2 = pse_cell(key_ff, pse_wrap_inc(loc_b.row), loc_b.col);
      end else begin
         // rectangle: swap columns
         enc_1 = pse_cell(key_ff, loc_a.row, loc_b.col);
         enc_2 = pse_cell(key_ff, loc_b.row, loc_a.col);
      end
   end

   assign rsp_bus.cipher_letter = (out_cnt_ff == 2'd2) ? out_e1_ff : out_e2_ff;
   assign rsp_bus.last_letter   = (out_cnt_ff == 2'd1) && out_last_ff;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff         <= KeyReset;
         pend_valid_ff  <= 1'b0;
         pend_letter_ff <= '0;
         s1_valid_ff    <= 1'b0;
         out_cnt_ff     <= 2'd0;
      end else begin
         // ignore writes past the last row
         if (csr_bus.valid && (csr_bus.reg_index < csr_index_type'(SqSize))) begin
            key_ff[csr_bus.reg_index] <= csr_bus.wdata;
         end
         pend_valid_ff  <= pend_valid_in;
         pend_letter_ff <= pend_letter_in;
         s1_valid_ff    <= s1_valid_in;
         if (s1_advance) begin
            out_cnt_ff <= 2'd2;
         end else if (rsp_xfer) begin
            out_cnt_ff <= out_cnt_ff - 2'd1;
         end
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer && emit) begin
         s1_a_ff    <= pair_a;
         s1_b_ff    <= pair_b;
         s1_last_ff <= req_bus.end_of_text;
      end
      if (s1_advance) begin
         out_e1_ff   <= 7'(AsciiUpperA + {3'b000, enc_1});
         out_e2_ff   <= 7'(AsciiUpperA + {3'b000, enc_2});
         out_last_ff <= s1_last_ff;
      end
   end

`ifndef SYNTHESIS
   a_out_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("result count out of range");

   a_pair_slot_free: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> (!s1_valid_ff || s1_advance))
      else $error("pair stage overwritten");

   a_end_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_bus.end_of_text) |=> !pend_valid_ff)
      else $error("letter still held after end of text");

   a_load_two: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> (out_cnt_ff == 2'd2))
      else $error("pair not loaded into result buffer");

   a_first_then_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && (out_cnt_ff == 2'd2)) |=> (out_cnt_ff == 2'd1))
      else $error("second letter lost");
`endif

endmodule

// ===== tb/pse_cipher_checker.sv =====
// ----------------------------------------------------------------------------
// Playfair cipher letter checker
// Watches the byte, letter and key-write channels of the encryptor, keeps its
// own copy of the key square and the held letter, and compares every letter
// transfer with the oldest predicted letter.
// ----------------------------------------------------------------------------
module pse_cipher_checker (
   input  logic clock,
   input  logic reset,
   pse_req_if   req_mon,
   pse_rsp_if   rsp_mon,
   pse_csr_if   csr_mon,
   output int   mismatches,
   output int   letters_awaited,
   output int   letters_checked
);
   import pse_pkg::*;

   typedef struct packed {
      logic [6:0] letter;
      logic       last;
   } cipher_letter_t;

   cipher_letter_t expected_letters[$];
   key_row_type    key_rows [SqSize];
   logic           held_valid;
   code_type       held_code;
   int             mismatch_tally;
   int             checked_tally;

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatch_tally++;
   endtask

   function automatic code_type cell_at(input int row, input int col);
      return key_rows[row][col*CodeWidth +: CodeWidth];
   endfunction

   // first hit in row-major order; a letter not in the square sits at 0,0
   function automatic void place_of(input code_type code, output int row, output int col);
      bit found;
      found = 1'b0;
      row   = 0;
      col   = 0;
      for (int r = 0; r < SqSize; r++) begin
         for (int c = 0; c < SqSize; c++) begin
            if (!found && cell_at(r, c) == code) begin
               found = 1'b1;
               row   = r;
               col   = c;
            end
         end
      end
   endfunction

   function automatic void queue_pair(input code_type first, input code_type second,
                                      input logic closing);
      int             r1, c1, r2, c2;
      code_type       e1, e2;
      cipher_letter_t item;
      place_of(first, r1, c1);
      place_of(second, r2, c2);
      if (r1 == r2) begin
         e1 = cell_at(r1, (c1 + 1) % SqSize);
         e2 = cell_at(r2, (c2 + 1) % SqSize);
      end else if (c1 == c2) begin
         e1 = cell_at((r1 + 1) % SqSize, c1);
         e2 = cell_at((r2 + 1) % SqSize, c2);
      end else begin
         e1 = cell_at(r1, c2);
         e2 = cell_at(r2, c1);
      end
      item.letter = 7'(AsciiUpperA) + 7'(e1);
      item.last   = 1'b0;
      expected_letters.push_back(item);
      item.letter = 7'(AsciiUpperA) + 7'(e2);
      item.last   = closing;
      expected_letters.push_back(item);
   endfunction

   task automatic predict_byte(input logic [7:0] value, input logic closing);
      logic     is_letter;
      code_type code;
      is_letter = 1'b0;
      code      = '0;
      if (value >= AsciiUpperA && value <= AsciiUpperZ) begin
         is_letter = 1'b1;
         code      = code_type'(value - AsciiUpperA);
      end else if (value >= AsciiLowerA && value <= AsciiLowerZ) begin
         is_letter = 1'b1;
         code      = code_type'(value - AsciiLowerA);
      end
      if (code == CodeJ) begin
         code = CodeI;
      end
      if (is_letter && held_valid) begin
         queue_pair(held_code, code, closing);
         held_valid = 1'b0;
         held_code  = '0;
      end else begin
         if (is_letter) begin
            held_valid = 1'b1;
            held_code  = code;
         end
         if (closing && held_valid) begin
            queue_pair(held_code, CodeX, 1'b1);
            held_valid = 1'b0;
            held_code  = '0;
         end
      end
   endtask

   task automatic check_letter(input logic [6:0] letter, input logic last);
      cipher_letter_t want;
      if (expected_letters.size() == 0) begin
         report_mismatch($sformatf("letter 0x%02h last %b with nothing expected",
                                   letter, last));
      end else begin
         want = expected_letters.pop_front();
         checked_tally++;
         if (letter !== want.letter) begin
            report_mismatch($sformatf("cipher_letter expected 0x%02h, got 0x%02h",
                                      want.letter, letter));
         end
         if (last !== want.last) begin
            report_mismatch($sformatf("last_letter expected %b, got %b on letter 0x%02h",
                                      want.last, last, letter));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < SqSize; r++) begin
            key_rows[r] = KeyReset[r];
         end
         held_valid = 1'b0;
         held_code  = '0;
         expected_letters.delete();
         mismatch_tally = 0;
         checked_tally  = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_letter(rsp_mon.cipher_letter, rsp_mon.last_letter);
         end
         if (csr_mon.valid && csr_mon.ready && csr_mon.reg_index < SqSize) begin
            key_rows[csr_mon.reg_index] = csr_mon.wdata;
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_byte(req_mon.in_byte, req_mon.end_of_text);
         end
      end
      mismatches      <= mismatch_tally;
      letters_awaited <= expected_letters.size();
      letters_checked <= checked_tally;
   end

endmodule

// ===== tb/tb_playfair_stream_encryptor_core.sv =====
// ----------------------------------------------------------------------------
// Playfair stream encryptor testbench
// Drives plaintext bytes and key-square writes into the encryptor, pulls the
// cipher letters out under three pacing modes, and leaves all prediction and
// comparison to the checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb_playfair_stream_encryptor_core;
   import pse_pkg::*;

   // kinds of key square loaded between traffic segments
   typedef enum {
      SquareDefault,
      SquareShuffled,
      SquareShuffledJ,
      SquareZeros,
      SquareOnes,
      SquareRaw
   } square_kind_type;

   localparam int SegmentItems = 136;
   localparam int SettleCycles = 8;
   localparam int DrainLimit   = 5000;

   logic clock;
   logic reset;

   pse_req_if req_bus ();
   pse_rsp_if rsp_bus ();
   pse_csr_if csr_bus ();

   int mismatch_total;
   int letters_awaited;
   int letters_checked;

   int req_idle_pct;
   int rsp_idle_pct;
   int bytes_sent;
   int counted_items;
   int squares_loaded;

   key_row_type next_square [SqSize];

   playfair_stream_encryptor_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pse_cipher_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_mon         (csr_bus),
      .mismatches      (mismatch_total),
      .letters_awaited (letters_awaited),
      .letters_checked (letters_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("Timed out with %0d letters still awaited", letters_awaited);
      $display("== FAIL ==");
      $finish;
   end

   // Letter sink: drop ready at random for the current pacing mode.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offer one byte, idling first at the sender's rate, and hold it until the
   // transfer. Valid stays high afterwards so back-to-back bytes need no gap.
   task automatic send_byte(input logic [7:0] value, input logic closing);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.in_byte     <= value;
      req_bus.end_of_text <= closing;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      bytes_sent++;
      // letters and end marks, for the summary
      if (closing || (value >= AsciiUpperA && value <= AsciiUpperZ) ||
          (value >= AsciiLowerA && value <= AsciiLowerZ)) begin
         counted_items++;
      end
   endtask

   // Drop valid, wait for every predicted letter, then let the pipeline empty
   // of bytes that produce no letter at all. The checker's count is registered,
   // so step past the last transfer before reading it.
   task automatic settle_block();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (letters_awaited != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_key_row(input csr_index_type index, input key_row_type value);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= index;
      csr_bus.wdata     <= value;
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // Write all five rows, then one index past the last row, which must be ignored.
   task automatic load_square();
      for (int r = 0; r < SqSize; r++) begin
         write_key_row(csr_index_type'(r), next_square[r]);
      end
      write_key_row(csr_index_type'($urandom_range((1 << IdxWidth) - 1, SqSize)),
                    key_row_type'($urandom));
      csr_bus.valid <= 1'b0;
      squares_loaded++;
   endtask

   task automatic build_square(input square_kind_type kind);
      code_type pool [SqSize*SqSize];
      code_type swap;
      int       n;
      int       pick;
      n = 0;
      for (int k = 0; k < 26; k++) begin
         if (code_type'(k) != CodeJ) begin
            pool[n] = code_type'(k);
            n++;
         end
      end
      for (int k = SqSize*SqSize - 1; k > 0; k--) begin
         pick       = $urandom_range(k);
         swap       = pool[k];
         pool[k]    = pool[pick];
         pool[pick] = swap;
      end
      for (int r = 0; r < SqSize; r++) begin
         case (kind)
            SquareDefault: begin
               next_square[r] = KeyReset[r];
            end
            SquareZeros: begin
               next_square[r] = '0;
            end
            SquareOnes: begin
               next_square[r] = '1;
            end
            SquareRaw: begin
               next_square[r] = key_row_type'($urandom);
            end
            default: begin
               for (int c = 0; c < SqSize; c++) begin
                  // the J variant leaves I out, so every I lands on row 0, column 0
                  if (kind == SquareShuffledJ && pool[r*SqSize + c] == CodeI) begin
                     next_square[r][c*CodeWidth +: CodeWidth] = CodeJ;
                  end else begin
                     next_square[r][c*CodeWidth +: CodeWidth] = pool[r*SqSize + c];
                  end
               end
            end
         endcase
      end
   endtask

   function automatic logic [7:0] random_letter();
      logic [7:0] code;
      code = 8'($urandom_range(25));
      return $urandom_range(1) ? AsciiUpperA + code : AsciiLowerA + code;
   endfunction

   // Mostly well-formed messages: letters with the odd stray byte, closed by an
   // end mark. The rest is raw noise with end marks at random.
   task automatic send_message();
      int         len;
      logic [7:0] value;
      if ($urandom_range(99) < 12) begin
         len = $urandom_range(6, 1);
         for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(255)), ($urandom_range(9) == 0));
         end
      end else begin
         len = $urandom_range(12);
         for (int k = 0; k < len; k++) begin
            value = ($urandom_range(99) < 80) ? random_letter() : 8'($urandom_range(255));
            send_byte(value, 1'b0);
         end
         value = $urandom_range(1) ? random_letter() : 8'($urandom_range(255));
         send_byte(value, 1'b1);
      end
   endtask

   // Directed bytes on the default square: pairs on one row, one column and a
   // rectangle, folding of J and of lower case, doubled letters, dropped bytes
   // on both sides of each letter range and at the top of the byte range, and
   // every way an end mark can meet a held letter.
   logic [7:0] directed_bytes [25] = '{
      8'h00, "M", "K", "u", "Z", "a", "F", "J", "j", "z", 8'hFF, 8'h80, 8'h40,
      8'h5B, 8'h60, 8'h7B, "A", "Q", " ", "L", "L", "B", ".", "X", "Z"
   };
   logic       directed_ends  [25] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0
   };

   square_kind_type square_plan [9] = '{
      SquareShuffled,  SquareZeros, SquareShuffledJ,
      SquareRaw,       SquareShuffled, SquareOnes,
      SquareShuffledJ, SquareRaw,   SquareDefault
   };

   initial begin
      int target;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.in_byte     <= '0;
      req_bus.end_of_text <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.reg_index   <= '0;
      csr_bus.wdata       <= '0;
      req_idle_pct   = 14;
      rsp_idle_pct   = 79;
      bytes_sent     = 0;
      counted_items  = 0;
      squares_loaded = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < 25; k++) begin
         send_byte(directed_bytes[k], directed_ends[k]);
      end

      // Three pacing modes: slow sink, slow source, then flat out. Each mode
      // runs three segments, each on a freshly loaded square.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 14;
               rsp_idle_pct = 79;
            end
            1: begin
               req_idle_pct = 79;
               rsp_idle_pct = 14;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            settle_block();
            build_square(square_plan[phase*3 + seg]);
            load_square();
            target = bytes_sent + SegmentItems;
            while (bytes_sent < target) begin
               send_message();
            end
         end
      end

      settle_block();
      $display("Sent %0d plaintext bytes (%0d letters or end marks) over %0d loaded key squares",
               bytes_sent, counted_items, squares_loaded);
      $display("Checked %0d cipher letters across three source/sink pacing modes",
               letters_checked);
      if (mismatch_total == 0 && letters_awaited == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d letters never arrived", mismatch_total, letters_awaited);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
